FILE: rtl/core/svbr_pkg.sv
`default_nettype none

package svbr_pkg;

   // Fixed field widths
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;

   // Header and instruction codes
   localparam logic [7:0] HDR_FF       = 8'hFF;
   localparam logic [7:0] HDR_FD       = 8'hFD;
   localparam logic [7:0] HDR_ZERO     = 8'h00;
   localparam logic [7:0] INSTR_STATUS = 8'h55;

   // Input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [15:0] CRC_POLY      = 16'h8005;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] GAP_MAX       = 16'hFFFF;

   // Parameter store write port
   typedef struct packed {
      logic                en;
      logic [INDEX_W-1:0]  addr;
      logic [7:0]          data;
   } svbr_wr_type;

   // Emit request for a packet that passed the CRC check
   typedef struct packed {
      logic                start;
      logic [7:0]          id;
      logic [7:0]          instr;
      logic [7:0]          err;
      logic [COUNT_W-1:0]  count;
   } svbr_job_type;

   // CRC-16, poly 0x8005, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/svbr_parser.sv
`default_nettype none

module svbr_parser
   import svbr_pkg::*;
#(
   parameter int MAX_PARAMS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire logic         req_command,
   input  wire logic [7:0]   req_rx_byte,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data,
   output svbr_wr_type       wr,
   output svbr_job_type      job
);

   typedef enum logic [3:0] {
      PH_H1, PH_H2, PH_H3, PH_H4, PH_ID, PH_LEN_LO, PH_LEN_HI,
      PH_INSTR, PH_ERR, PH_PARAM, PH_CRC_LO, PH_CRC_HI
   } phase_type;

   phase_type            phase_ff, phase_in, ph;
   logic [15:0]          gap_ff, gap_in;
   logic [15:0]          timeout_ff, timeout_in;
   logic [15:0]          len_ff, len_in;
   logic [COUNT_W-1:0]   expected_ff, expected_in;
   logic [COUNT_W-1:0]   rcvd_ff, rcvd_in, rcvd_inc;
   logic [15:0]          crc_ff, crc_in, crc_next;
   logic [7:0]           crc_lo_ff, crc_lo_in;
   logic [7:0]           id_ff, id_in;
   logic [7:0]           instr_ff, instr_in;
   logic [7:0]           err_ff, err_in;
   logic [15:0]          overhead, diff;
   logic                 accept;

   assign accept   = req_valid & req_ready;
   assign crc_next = crc16_byte((ph == PH_H1) ? 16'h0000 : crc_ff, req_rx_byte);
   assign rcvd_inc = rcvd_ff + COUNT_W'(1);
   assign overhead = (req_rx_byte == INSTR_STATUS) ? 16'd4 : 16'd3;
   assign diff     = len_ff - overhead;

   // Decode one byte or tick
   always_comb begin
      phase_in    = phase_ff;
      gap_in      = gap_ff;
      timeout_in  = timeout_ff;
      len_in      = len_ff;
      expected_in = expected_ff;
      rcvd_in     = rcvd_ff;
      crc_in      = crc_ff;
      crc_lo_in   = crc_lo_ff;
      id_in       = id_ff;
      instr_in    = instr_ff;
      err_in      = err_ff;
      wr          = '0;
      job.start   = 1'b0;
      job.id      = id_ff;
      job.instr   = instr_ff;
      job.err     = err_ff;
      job.count   = expected_ff;
      ph          = (gap_ff >= timeout_ff) ? PH_H1 : phase_ff;

      if (csr_wr_en) begin
         timeout_in = csr_wr_data;
      end

      if (accept && req_command == CMD_TICK) begin
         if (gap_ff != GAP_MAX) begin
            gap_in = gap_ff + 16'd1;
         end
      end else if (accept) begin
         gap_in = '0;
         unique case (ph)
            PH_H1: begin
               phase_in = PH_H1;
               if (req_rx_byte == HDR_FF) begin
                  crc_in   = crc_next;
                  phase_in = PH_H2;
               end
            end
            PH_H2: begin
               phase_in = PH_H1;
               if (req_rx_byte == HDR_FF) begin
                  crc_in   = crc_next;
                  phase_in = PH_H3;
               end
            end
            PH_H3: begin
               phase_in = PH_H1;
               if (req_rx_byte == HDR_FD) begin
                  crc_in   = crc_next;
                  phase_in = PH_H4;
               end
            end
            PH_H4: begin
               phase_in = PH_H1;
               if (req_rx_byte == HDR_ZERO) begin
                  crc_in   = crc_next;
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               id_in    = req_rx_byte;
               crc_in   = crc_next;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in   = {8'h00, req_rx_byte};
               crc_in   = crc_next;
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len_in   = {req_rx_byte, len_ff[7:0]};
               crc_in   = crc_next;
               phase_in = PH_INSTR;
            end
            PH_INSTR: begin
               instr_in = req_rx_byte;
               err_in   = '0;
               crc_in   = crc_next;
               // drop short or oversized packets
               if (len_ff < overhead || diff > 16'(MAX_PARAMS)) begin
                  phase_in = PH_H1;
               end else begin
                  expected_in = diff[COUNT_W-1:0];
                  rcvd_in     = '0;
                  if (req_rx_byte == INSTR_STATUS) begin
                     phase_in = PH_ERR;
                  end else begin
                     phase_in = (diff == 16'd0) ? PH_CRC_LO : PH_PARAM;
                  end
               end
            end
            PH_ERR: begin
               err_in   = req_rx_byte;
               crc_in   = crc_next;
               rcvd_in  = '0;
               phase_in = (expected_ff == '0) ? PH_CRC_LO : PH_PARAM;
            end
            PH_PARAM: begin
               wr.en    = 1'b1;
               wr.addr  = rcvd_ff[INDEX_W-1:0];
               wr.data  = req_rx_byte;
               crc_in   = crc_next;
               rcvd_in  = rcvd_inc;
               if (rcvd_inc >= expected_ff) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               crc_lo_in = req_rx_byte;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               phase_in  = PH_H1;
               job.start = ({req_rx_byte, crc_lo_ff} == crc_ff);
            end
            default: begin
               phase_in = PH_H1;
            end
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_H1;
         gap_ff      <= '0;
         timeout_ff  <= TIMEOUT_RESET;
         len_ff      <= '0;
         expected_ff <= '0;
         rcvd_ff     <= '0;
         crc_ff      <= '0;
         crc_lo_ff   <= '0;
         id_ff       <= '0;
         instr_ff    <= '0;
         err_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         gap_ff      <= gap_in;
         timeout_ff  <= timeout_in;
         len_ff      <= len_in;
         expected_ff <= expected_in;
         rcvd_ff     <= rcvd_in;
         crc_ff      <= crc_in;
         crc_lo_ff   <= crc_lo_in;
         id_ff       <= id_in;
         instr_ff    <= instr_in;
         err_ff      <= err_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/svbr_emitter.sv
`default_nettype none

module svbr_emitter
   import svbr_pkg::*;
#(
   parameter int MAX_PARAMS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire svbr_wr_type         wr,
   input  wire svbr_job_type        job,
   output logic                     idle,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_packet_id,
   output logic [7:0]               rsp_instruction,
   output logic [7:0]               rsp_error_code,
   output logic [COUNT_W-1:0]       rsp_param_count,
   output logic [INDEX_W-1:0]       rsp_param_index,
   output logic [7:0]               rsp_param_byte,
   output logic                     rsp_has_param,
   output logic                     rsp_last
);

   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

   typedef enum logic [1:0] {EM_IDLE, EM_READ, EM_LOAD} em_state_type;

   em_state_type          state_ff, state_in;
   logic [INDEX_W-1:0]    k_ff, k_in;
   logic                  empty_ff, empty_in;
   svbr_job_type          job_ff, job_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            mem [MAX_PARAMS];
   logic [7:0]            rd_data_ff;
   logic                  rd_en, load, is_last;

   assign idle    = (state_ff == EM_IDLE);
   assign rd_en   = (state_ff == EM_READ);
   assign load    = (state_ff == EM_LOAD) && (!valid_ff || rsp_ready);
   assign is_last = empty_ff || ((COUNT_W'(k_ff) + COUNT_W'(1)) == job_ff.count);

   // Parameter store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[IDX_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[k_ff[IDX_W-1:0]];
      end
   end

   // Sequence reads and loads of the output register
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      empty_in = empty_ff;
      job_in   = job_ff;
      valid_in = valid_ff & ~rsp_ready;
      unique case (state_ff)
         EM_IDLE: begin
            if (job.start) begin
               job_in   = job;
               k_in     = '0;
               empty_in = (job.count == '0);
               state_in = (job.count == '0) ? EM_LOAD : EM_READ;
            end
         end
         EM_READ: begin
            state_in = EM_LOAD;
         end
         EM_LOAD: begin
            if (load) begin
               valid_in = 1'b1;
               if (is_last) begin
                  state_in = EM_IDLE;
               end else begin
                  k_in     = k_ff + INDEX_W'(1);
                  state_in = EM_READ;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   // Hold state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      k_ff     <= k_in;
      empty_ff <= empty_in;
      job_ff   <= job_in;
      if (load) begin
         rsp_packet_id   <= job_ff.id;
         rsp_instruction <= job_ff.instr;
         rsp_error_code  <= job_ff.err;
         rsp_param_count <= job_ff.count;
         rsp_param_index <= k_ff;
         rsp_param_byte  <= empty_ff ? 8'h00 : rd_data_ff;
         rsp_has_param   <= ~empty_ff;
         rsp_last        <= is_last;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/servo_bus_packet_receiver_top.sv
// Each byte or tick is taken while no packet is being emitted.
// After a good CRC high byte the first parameter is read from the store and
// then loaded (an empty packet is loaded directly); later ones repeat both.
// Input is held off while a packet's results are read out of the parameter store.
// Synchronous active-high reset; timeout_ms resets to 100; no clearing pass.
`default_nettype none

module servo_bus_packet_receiver_top
   import svbr_pkg::*;
#(
   parameter int MAX_PARAMS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_command,
   input  wire logic [7:0]          req_rx_byte,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_packet_id,
   output logic [7:0]               rsp_instruction,
   output logic [7:0]               rsp_error_code,
   output logic [COUNT_W-1:0]       rsp_param_count,
   output logic [INDEX_W-1:0]       rsp_param_index,
   output logic [7:0]               rsp_param_byte,
   output logic                     rsp_has_param,
   output logic                     rsp_last,
   input  wire logic                csr_wr_en,
   input  wire logic [15:0]         csr_wr_data
);

   svbr_wr_type   wr;
   svbr_job_type  job;
   logic          em_idle;

   // Take input only while the emitter is idle
   assign req_ready = em_idle;

   svbr_parser #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .wr          (wr),
      .job         (job)
   );

   svbr_emitter #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_emitter (
      .clock           (clock),
      .reset           (reset),
      .wr              (wr),
      .job             (job),
      .idle            (em_idle),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_instruction (rsp_instruction),
      .rsp_error_code  (rsp_error_code),
      .rsp_param_count (rsp_param_count),
      .rsp_param_index (rsp_param_index),
      .rsp_param_byte  (rsp_param_byte),
      .rsp_has_param   (rsp_has_param),
      .rsp_last        (rsp_last)
   );

   // An emit request only arrives while the emitter is free, and then blocks input
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      job.start |-> em_idle) else $error("emit request while busy");

   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      job.start |=> !req_ready) else $error("input not held off after emit request");

   // Index stays within the packet's count
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_param |-> COUNT_W'(rsp_param_index) < rsp_param_count)
      else $error("parameter index beyond count");

   // The last item of a non-empty packet carries the final index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_param && rsp_last
      |-> (COUNT_W'(rsp_param_index) + COUNT_W'(1)) == rsp_param_count)
      else $error("last flag on wrong index");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import svbr_pkg::*;

   localparam int PARAM_LIMIT   = 64;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 3_000_000;

   // One item on the request channel: a received byte or a millisecond tick
   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } bus_item_type;

   // One parameter result as it leaves the block
   typedef struct packed {
      logic [7:0]         id;
      logic [7:0]         instr;
      logic [7:0]         err;
      logic [COUNT_W-1:0] count;
      logic [INDEX_W-1:0] index;
      logic [7:0]         pbyte;
      logic               has;
      logic               last;
   } param_rsp_type;

   // Receive framing states
   typedef enum logic [3:0] {
      ST_H1, ST_H2, ST_H3, ST_H4, ST_ID, ST_LEN_LO, ST_LEN_HI,
      ST_INSTR, ST_ERR, ST_PARAM, ST_CRC_LO, ST_CRC_HI
   } rx_state_type;

   // Result channel stall styles
   typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_pace_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = CMD_TICK;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [7:0]          rsp_packet_id;
   logic [7:0]          rsp_instruction;
   logic [7:0]          rsp_error_code;
   logic [COUNT_W-1:0]  rsp_param_count;
   logic [INDEX_W-1:0]  rsp_param_index;
   logic [7:0]          rsp_param_byte;
   logic                rsp_has_param;
   logic                rsp_last;
   logic                csr_wr_en = 1'b0;
   logic [15:0]         csr_wr_data = 16'h0000;

   servo_bus_packet_receiver_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packet_id   (rsp_packet_id),
      .rsp_instruction (rsp_instruction),
      .rsp_error_code  (rsp_error_code),
      .rsp_param_count (rsp_param_count),
      .rsp_param_index (rsp_param_index),
      .rsp_param_byte  (rsp_param_byte),
      .rsp_has_param   (rsp_has_param),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Stimulus and expectation stores
   bus_item_type  tx_items[$];
   param_rsp_type pending_results[$];
   int            items_queued = 0;
   int            fail_count = 0;
   int            cycle_count = 0;
   logic          item_taken = 1'b0;

   // Predicted receiver state
   logic [15:0]  timeout_ticks = TIMEOUT_RESET;
   rx_state_type rx_state = ST_H1;
   logic [15:0]  gap_ticks = 16'h0000;
   logic [15:0]  pkt_len = 16'h0000;
   logic [15:0]  params_due = 16'h0000;
   logic [6:0]   params_seen = 7'h00;
   logic [15:0]  crc_acc = 16'h0000;
   logic [7:0]   crc_lo = 8'h00;
   logic [7:0]   hold_id = 8'h00;
   logic [7:0]   hold_instr = 8'h00;
   logic [7:0]   hold_err = 8'h00;
   logic [7:0]   param_mem[PARAM_LIMIT];

   // Driver pacing
   int           burst_left = 0;
   int           gap_left = 0;
   bus_item_type next_item;

   // Receiver pacing
   rx_pace_type  stall_mode = RX_FREE;
   int           mode_left = 0;
   logic [7:0]   stall_phase = 8'h00;

   // CRC-16 0x8005, one bit at a time, MSB first
   function automatic logic [15:0] crc8005_shift(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ data[i];
         r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic logic [15:0] std_len(input logic [7:0] instr, input int n);
      return 16'(n + ((instr == INSTR_STATUS) ? 4 : 3));
   endfunction

   function automatic string show_rsp(input param_rsp_type r);
      return $sformatf("id=%h ins=%h err=%h cnt=%0d idx=%0d byte=%h has=%b last=%b",
                       r.id, r.instr, r.err, r.count, r.index, r.pbyte, r.has, r.last);
   endfunction

   // Advance the receiver by one accepted item and queue the results it releases
   function automatic void predict_item(input logic cmd, input logic [7:0] b);
      logic [15:0]   ovh;
      logic [15:0]   got;
      param_rsp_type r;
      if (cmd == CMD_TICK) begin
         if (gap_ticks != GAP_MAX) gap_ticks++;
         return;
      end
      // restart the hunt after a long silence, then look at the byte
      if (gap_ticks >= timeout_ticks) rx_state = ST_H1;
      gap_ticks = 16'h0000;
      case (rx_state)
         ST_H1: begin
            if (b == HDR_FF) begin
               crc_acc = crc8005_shift(16'h0000, b);
               rx_state = ST_H2;
            end
         end
         ST_H2: begin
            if (b == HDR_FF) begin
               crc_acc = crc8005_shift(crc_acc, b);
               rx_state = ST_H3;
            end else rx_state = ST_H1;
         end
         ST_H3: begin
            if (b == HDR_FD) begin
               crc_acc = crc8005_shift(crc_acc, b);
               rx_state = ST_H4;
            end else rx_state = ST_H1;
         end
         ST_H4: begin
            if (b == HDR_ZERO) begin
               crc_acc = crc8005_shift(crc_acc, b);
               rx_state = ST_ID;
            end else rx_state = ST_H1;
         end
         ST_ID: begin
            hold_id = b;
            crc_acc = crc8005_shift(crc_acc, b);
            rx_state = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            pkt_len = {8'h00, b};
            crc_acc = crc8005_shift(crc_acc, b);
            rx_state = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            pkt_len[15:8] = b;
            crc_acc = crc8005_shift(crc_acc, b);
            rx_state = ST_INSTR;
         end
         ST_INSTR: begin
            ovh = (b == INSTR_STATUS) ? 16'd4 : 16'd3;
            hold_instr = b;
            hold_err = 8'h00;
            crc_acc = crc8005_shift(crc_acc, b);
            // drop short or oversized packets right here
            if (pkt_len < ovh || (pkt_len - ovh) > PARAM_LIMIT) begin
               rx_state = ST_H1;
            end else begin
               params_due = pkt_len - ovh;
               params_seen = 7'h00;
               if (b == INSTR_STATUS) rx_state = ST_ERR;
               else rx_state = (params_due == 0) ? ST_CRC_LO : ST_PARAM;
            end
         end
         ST_ERR: begin
            hold_err = b;
            crc_acc = crc8005_shift(crc_acc, b);
            params_seen = 7'h00;
            rx_state = (params_due == 0) ? ST_CRC_LO : ST_PARAM;
         end
         ST_PARAM: begin
            param_mem[params_seen[5:0]] = b;
            crc_acc = crc8005_shift(crc_acc, b);
            params_seen = params_seen + 7'd1;
            if ({9'h000, params_seen} >= params_due) rx_state = ST_CRC_LO;
         end
         ST_CRC_LO: begin
            crc_lo = b;
            rx_state = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            got = {b, crc_lo};
            rx_state = ST_H1;
            if (got == crc_acc) begin
               r.id = hold_id;
               r.instr = hold_instr;
               r.err = hold_err;
               if (params_due == 0) begin
                  r.count = '0;
                  r.index = '0;
                  r.pbyte = 8'h00;
                  r.has = 1'b0;
                  r.last = 1'b1;
                  pending_results.push_back(r);
               end else begin
                  for (int k = 0; k < params_due; k++) begin
                     r.count = params_due[COUNT_W-1:0];
                     r.index = k[INDEX_W-1:0];
                     r.pbyte = param_mem[k];
                     r.has = 1'b1;
                     r.last = (k == params_due - 1);
                     pending_results.push_back(r);
                  end
               end
            end
         end
         default: rx_state = ST_H1;
      endcase
   endfunction

   // Stimulus helpers
   task automatic push_byte(input logic [7:0] b);
      tx_items.push_back('{cmd: CMD_BYTE, data: b});
      items_queued++;
   endtask

   task automatic push_ticks(input int n);
      repeat (n) begin
         tx_items.push_back('{cmd: CMD_TICK, data: 8'($urandom_range(0, 255))});
         items_queued++;
      end
   endtask

   // Queue one framed packet; fill < 0 gives random parameter bytes
   task automatic send_packet(input logic [7:0] id, input logic [7:0] instr,
                              input logic [7:0] err, input int nparams,
                              input logic [15:0] len, input logic [15:0] crc_xor,
                              input int tick_max, input int stall_at, input int stall_len,
                              input int fill);
      logic [7:0]  frame[$];
      logic [15:0] c;
      frame = {HDR_FF, HDR_FF, HDR_FD, HDR_ZERO, id, len[7:0], len[15:8], instr};
      if (instr == INSTR_STATUS) frame.push_back(err);
      repeat (nparams) frame.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      c = 16'h0000;
      foreach (frame[i]) c = crc8005_shift(c, frame[i]);
      c = c ^ crc_xor;
      frame.push_back(c[7:0]);
      frame.push_back(c[15:8]);
      foreach (frame[i]) begin
         if (i == stall_at) push_ticks(stall_len);
         else if (tick_max > 0) push_ticks($urandom_range(0, tick_max));
         push_byte(frame[i]);
      end
   endtask

   // Wait until all items are sent and every expected result has come, then let the block settle
   task automatic drain_wait();
      do @(posedge clock);
      while (tx_items.size() != 0 || req_valid || pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      timeout_ticks = v;
   endtask

   // Mostly well-formed packets, with broken ones, noise and silences mixed in
   task automatic queue_random_traffic(input int goal);
      int          stop_at;
      int          pick;
      int          n;
      int          qt;
      logic [7:0]  instr;
      logic [15:0] len;
      stop_at = items_queued + goal;
      while (items_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         instr = ($urandom_range(0, 2) == 0) ? INSTR_STATUS : 8'($urandom_range(0, 255));
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, PARAM_LIMIT) : $urandom_range(0, 8);
         qt = 0;
         if (timeout_ticks > 16'd1 && $urandom_range(0, 1) == 1)
            qt = (timeout_ticks > 16'd5) ? 4 : int'(timeout_ticks) - 1;
         if (pick < 62) begin
            send_packet(8'($urandom_range(0, 255)), instr, 8'($urandom_range(0, 255)), n,
                        std_len(instr, n), 16'h0000, qt, -1, 0, -1);
         end else if (pick < 70) begin
            send_packet(8'($urandom_range(0, 255)), instr, 8'($urandom_range(0, 255)), n,
                        std_len(instr, n), 16'($urandom_range(1, 65535)), qt, -1, 0, -1);
         end else if (pick < 77) begin
            if ($urandom_range(0, 1) == 1)
               len = 16'($urandom_range(0, (instr == INSTR_STATUS) ? 3 : 2));
            else if ($urandom_range(0, 3) == 0)
               len = 16'hFFFF;
            else
               len = std_len(instr, $urandom_range(PARAM_LIMIT + 1, 200));
            send_packet(8'($urandom_range(0, 255)), instr, 8'($urandom_range(0, 255)),
                        $urandom_range(0, 4), len, 16'h0000, qt, -1, 0, -1);
         end else if (pick < 85) begin
            if (timeout_ticks <= 16'd200)
               send_packet(8'($urandom_range(0, 255)), instr, 8'($urandom_range(0, 255)), n,
                           std_len(instr, n), 16'h0000, 0, $urandom_range(0, 8),
                           int'(timeout_ticks) + $urandom_range(0, 4), -1);
            else
               push_ticks($urandom_range(1, 8));
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 6))
               push_byte(($urandom_range(0, 2) == 0) ? HDR_FF : 8'($urandom_range(0, 255)));
         end else begin
            push_ticks($urandom_range(1, 8));
         end
         if ($urandom_range(0, 24) == 0) drain_wait();
      end
   endtask

   // Clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Request driver: bursts of items with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !item_taken) begin
         // hold the item until it is taken
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (tx_items.size() == 0) begin
         req_valid <= 1'b0;
      end else begin
         next_item = tx_items.pop_front();
         req_valid <= 1'b1;
         req_command <= next_item.cmd;
         req_rx_byte <= next_item.data;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            burst_left--;
         end
      end
   end

   // Result receiver: switch between stall styles every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = rx_pace_type'($urandom_range(0, 3));
         mode_left = $urandom_range(16, 128);
      end else begin
         mode_left--;
      end
      stall_phase = stall_phase + 8'd1;
      case (stall_mode)
         RX_FREE:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (stall_phase[2:0] != 3'b101) && !stall_phase[4];
      endcase
   end

   // Monitor: predict on each taken item, check each taken result
   always @(posedge clock) begin : watch_ports
      param_rsp_type got;
      param_rsp_type want;
      item_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            item_taken = 1'b1;
            predict_item(req_command, req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{id: rsp_packet_id, instr: rsp_instruction, err: rsp_error_code,
                    count: rsp_param_count, index: rsp_param_index, pbyte: rsp_param_byte,
                    has: rsp_has_param, last: rsp_last};
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result %s", $realtime, show_rsp(got));
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", show_rsp(want));
                     $display("   actual   %s", show_rsp(got));
                  end
               end
            end
         end
      end
   end

   // Test sequence
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed cases at the reset timeout
      send_packet(8'h00, 8'h00, 8'h00, 0, std_len(8'h00, 0), 16'h0000, 0, -1, 0, -1);
      send_packet(8'hFF, INSTR_STATUS, 8'hFF, 0, std_len(INSTR_STATUS, 0), 16'h0000,
                  0, -1, 0, -1);
      send_packet(8'h01, 8'hFF, 8'h00, 3, std_len(8'hFF, 3), 16'h0000, 0, -1, 0, 8'hFF);
      send_packet(8'hFE, INSTR_STATUS, 8'h80, 2, std_len(INSTR_STATUS, 2), 16'h0000,
                  0, -1, 0, 8'h00);
      send_packet(8'h5A, 8'h03, 8'h00, PARAM_LIMIT, std_len(8'h03, PARAM_LIMIT), 16'h0000,
                  0, -1, 0, -1);
      // oversized, short and corrupted packets are dropped
      send_packet(8'h07, 8'h03, 8'h00, 0, std_len(8'h03, PARAM_LIMIT + 1), 16'h0000,
                  0, -1, 0, -1);
      send_packet(8'h07, 8'h03, 8'h00, 0, 16'hFFFF, 16'h0000, 0, -1, 0, -1);
      send_packet(8'h08, INSTR_STATUS, 8'h01, 0, 16'd3, 16'h0000, 0, -1, 0, -1);
      send_packet(8'h09, 8'h02, 8'h00, 0, 16'd2, 16'h0000, 0, -1, 0, -1);
      send_packet(8'h0A, 8'h02, 8'h00, 4, std_len(8'h02, 4), 16'h0001, 0, -1, 0, -1);
      // header mismatches at the second, third and fourth positions
      push_byte(HDR_FF); push_byte(8'h00);
      push_byte(HDR_FF); push_byte(HDR_FF); push_byte(8'h00);
      push_byte(HDR_FF); push_byte(HDR_FF); push_byte(HDR_FD); push_byte(8'h01);
      send_packet(8'h0B, 8'h01, 8'h00, 1, std_len(8'h01, 1), 16'h0000, 0, -1, 0, -1);
      // a stray FF ahead of a header throws the header off
      push_byte(HDR_FF);
      send_packet(8'h0C, 8'h01, 8'h00, 1, std_len(8'h01, 1), 16'h0000, 0, -1, 0, -1);
      // gap of exactly the reset timeout restarts the hunt
      send_packet(8'h12, 8'h04, 8'h00, 2, std_len(8'h04, 2), 16'h0000, 0, 4, 100, -1);
      drain_wait();

      // Zero timeout: no packet is ever accepted
      write_timeout(16'h0000);
      send_packet(8'h21, 8'h01, 8'h00, 2, std_len(8'h01, 2), 16'h0000, 0, -1, 0, -1);
      send_packet(8'h22, INSTR_STATUS, 8'h05, 0, std_len(INSTR_STATUS, 0), 16'h0000,
                  0, -1, 0, -1);
      drain_wait();

      // Shortest nonzero timeout: a single tick between bytes breaks the packet
      write_timeout(16'h0001);
      send_packet(8'h31, 8'h01, 8'h00, 2, std_len(8'h01, 2), 16'h0000, 0, -1, 0, -1);
      send_packet(8'h32, 8'h01, 8'h00, 2, std_len(8'h01, 2), 16'h0000, 0, 5, 1, -1);
      drain_wait();

      // Random traffic over a short and the longest timeout
      write_timeout(16'($urandom_range(2, 40)));
      queue_random_traffic(50);
      drain_wait();
      write_timeout(16'hFFFF);
      queue_random_traffic(30);
      drain_wait();

      if (fail_count == 0 && pending_results.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/svbr_pkg.sv
rtl/core/svbr_parser.sv
rtl/core/svbr_emitter.sv
rtl/core/servo_bus_packet_receiver_top.sv
tb/sv/tb_top.sv
